// ===== src/rc5_pkg.sv =====
// shared widths, register indexes and threshold helpers for the rc5 edge timing decoder
`default_nettype none

package rc5_pkg;

    localparam int GAP_W   = 16;
    localparam int TIME_W  = 14;
    localparam int ADDR_W  = 5;
    localparam int CMD_W   = 6;
    localparam int SHIFT_W = 16;
    localparam int ACC_W   = 20;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;
    localparam int CFG_IDX_W   = 2;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_TIME    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_ALL  = 2'd2;

    localparam logic [TIME_W-1:0] BIT_TIME_RST    = 14'd1778;
    localparam logic [ADDR_W-1:0] OWN_ADDRESS_RST = 5'd0;
    localparam logic              ACCEPT_ALL_RST  = 1'b1;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    localparam int SHIFT_FRAME_BIT  = 13;
    localparam int SHIFT_TOGGLE_BIT = 11;

    // restart limit: 3 * t, compared against 2 * gap
    function automatic logic [15:0] times3(input logic [TIME_W-1:0] t);
        return {2'b00, t} + {1'b0, t, 1'b0};
    endfunction

    // low sample limit: 4 * t, compared against 5 * acc
    function automatic logic [15:0] times4(input logic [TIME_W-1:0] t);
        return {t, 2'b00};
    endfunction

    // high sample limit: 6 * t, compared against 5 * acc
    function automatic logic [16:0] times6(input logic [TIME_W-1:0] t);
        return {1'b0, t, 2'b00} + {2'b00, t, 1'b0};
    endfunction

endpackage

`default_nettype wire

// ===== src/rc5_edge_timing_decoder_top.sv =====
// rc5 edge timing decoder: one edge beat in, at most one frame beat out
// a frame beat passes the input stage and output stage registers; a stalled output holds both
// throughput: one edge beat per cycle while the output is not stalled
// thresholds are kept premultiplied in registers so each edge needs only adds and compares
// reset: async active low; clears frame shift, time accumulator, valids and config to defaults
`default_nettype none

module rc5_edge_timing_decoder_top
    import rc5_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [15:0] edge_gap_us, [16] level_low, [23:17] zero
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,

    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [0] toggle_bit, [5:1] device_addr, [11:6] command_code, [15:12] zero
    output logic [OUT_TDATA_W-1:0]      m_tdata,

    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [TIME_W-1:0]      cfg_data
);

    // config, thresholds held premultiplied
    logic [15:0]        thr3_reg;
    logic [15:0]        thr4_reg;
    logic [16:0]        thr6_reg;
    logic [ADDR_W-1:0]  own_address_reg;
    logic               accept_all_reg;

    // input stage
    logic               in_valid_reg;
    logic [GAP_W-1:0]   gap_reg;
    logic               level_low_reg;

    // decoder state
    logic [SHIFT_W-1:0] frame_shift_reg;
    logic [SHIFT_W-1:0] frame_shift_next;
    logic [ACC_W-1:0]   time_accum_reg;
    logic [ACC_W-1:0]   time_accum_next;

    // output stage
    logic               out_valid_reg;
    logic               toggle_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [CMD_W-1:0]   cmd_reg;

    logic               out_free;
    logic               proc_fire;
    logic               restart;
    logic [ACC_W:0]     acc_sum;
    logic [ACC_W-1:0]   acc_sat;
    logic [ACC_W+2:0]   acc5;
    logic               sample;
    logic [SHIFT_W-1:0] shift_in;
    logic               addr_ok;
    logic               emit;

    assign out_free  = !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr3_reg        <= times3(BIT_TIME_RST);
            thr4_reg        <= times4(BIT_TIME_RST);
            thr6_reg        <= times6(BIT_TIME_RST);
            own_address_reg <= OWN_ADDRESS_RST;
            accept_all_reg  <= ACCEPT_ALL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BIT_TIME:
                begin
                    thr3_reg <= times3(cfg_data);
                    thr4_reg <= times4(cfg_data);
                    thr6_reg <= times6(cfg_data);
                end
                CFG_OWN_ADDRESS: own_address_reg <= cfg_data[ADDR_W-1:0];
                CFG_ACCEPT_ALL:  accept_all_reg  <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            gap_reg       <= s_tdata[GAP_W-1:0];
            level_low_reg <= s_tdata[GAP_W];
        end
    end

    always_comb
    begin
        restart  = {gap_reg, 1'b0} > {1'b0, thr3_reg};
        acc_sum  = {1'b0, time_accum_reg} + {{(ACC_W+1-GAP_W){1'b0}}, gap_reg};
        acc_sat  = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        acc5     = {1'b0, acc_sat, 2'b00} + {3'b000, acc_sat};
        // strictly between 0.8 and 1.2 bit times
        sample   = (acc5 < {6'd0, thr6_reg}) && (acc5 > {7'd0, thr4_reg});
        shift_in = {frame_shift_reg[SHIFT_W-2:0], level_low_reg};
        addr_ok  = (shift_in[10:6] == own_address_reg) || accept_all_reg;
        emit     = !restart && sample && shift_in[SHIFT_FRAME_BIT] && addr_ok;

        frame_shift_next = frame_shift_reg;
        time_accum_next  = time_accum_reg;
        if (proc_fire)
        begin
            if (restart)
            begin
                frame_shift_next = {{(SHIFT_W-1){1'b0}}, 1'b1};
                time_accum_next  = '0;
            end
            else if (sample)
            begin
                frame_shift_next = shift_in;
                time_accum_next  = '0;
            end
            else
                time_accum_next = acc_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_shift_reg <= '0;
            time_accum_reg  <= '0;
        end
        else
        begin
            frame_shift_reg <= frame_shift_next;
            time_accum_reg  <= time_accum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (proc_fire && emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && emit)
        begin
            toggle_reg <= shift_in[SHIFT_TOGGLE_BIT];
            addr_reg   <= shift_in[10:6];
            cmd_reg    <= shift_in[CMD_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, cmd_reg, addr_reg, toggle_reg};

`ifndef SYNTHESIS
    a_restart_state: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && restart |=> (frame_shift_reg == 16'd1) && (time_accum_reg == '0))
        else $error("restart did not preset frame state");

    a_emit_frame_bit: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && emit |=> frame_shift_reg[SHIFT_FRAME_BIT] && m_tvalid)
        else $error("frame beat without frame bit in shift");

    a_rise_from_proc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(proc_fire && emit))
        else $error("output beat raised without a decoded frame");

    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && m_tvalid && !m_tready)
        else $error("input stalled while pipeline could move");

    a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !proc_fire |=> $stable(frame_shift_reg) && $stable(time_accum_reg))
        else $error("decoder state moved without an edge beat");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// testbench for the rc5 edge timing decoder: frame stimulus, frame predictor and output checks
`timescale 1ns / 100ps

module tb
    import rc5_pkg::*;
;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [CMD_W-1:0]  command_code;
        logic [ADDR_W-1:0] device_addr;
        logic              toggle_bit;
    } rc5_frame_t;

    // keeps its own decoder state and the frames still due on the output
    class rc5_frame_board;
        logic [TIME_W-1:0]  bit_time;
        logic [ADDR_W-1:0]  own_addr;
        logic               accept_any;
        logic [SHIFT_W-1:0] frame_bits;
        logic [ACC_W-1:0]   elapsed_us;
        rc5_frame_t         frames_due[$];
        int                 errors;

        function new();
            bit_time   = BIT_TIME_RST;
            own_addr   = OWN_ADDRESS_RST;
            accept_any = ACCEPT_ALL_RST;
            frame_bits = '0;
            elapsed_us = '0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
            case (idx)
                CFG_BIT_TIME:    bit_time   = value;
                CFG_OWN_ADDRESS: own_addr   = value[ADDR_W-1:0];
                CFG_ACCEPT_ALL:  accept_any = value[0];
                default: ;
            endcase
        endfunction

        function void note_edge(logic [GAP_W-1:0] gap, logic low);
            int unsigned g;
            int unsigned t;
            int unsigned total;
            rc5_frame_t  f;
            g = 32'(gap);
            t = 32'(bit_time);
            // gap above 1.5 bit times starts a new frame
            if (g * 2 > t * 3) begin
                frame_bits = SHIFT_W'(1);
                elapsed_us = '0;
                return;
            end
            total = 32'(elapsed_us) + g;
            if (total > 32'(ACC_MAX))
                total = 32'(ACC_MAX);
            elapsed_us = ACC_W'(total);
            // strictly inside 0.8 .. 1.2 bit times
            if (!(total * 5 < t * 6 && total * 5 > t * 4))
                return;
            elapsed_us = '0;
            frame_bits = {frame_bits[SHIFT_W-2:0], low};
            if (!frame_bits[SHIFT_FRAME_BIT])
                return;
            f.device_addr = frame_bits[10:6];
            if (f.device_addr != own_addr && !accept_any)
                return;
            f.toggle_bit   = frame_bits[SHIFT_TOGGLE_BIT];
            f.command_code = frame_bits[CMD_W-1:0];
            frames_due.push_back(f);
        endfunction

        function void check_frame(logic [OUT_TDATA_W-1:0] beat);
            rc5_frame_t got;
            rc5_frame_t want;
            got = beat[$bits(rc5_frame_t)-1:0];
            if (frames_due.size() == 0) begin
                $error("frame beat %h with no frame due", beat);
                errors++;
                return;
            end
            want = frames_due.pop_front();
            if (got.toggle_bit !== want.toggle_bit) begin
                $error("toggle_bit: expected %0d, got %0d", want.toggle_bit, got.toggle_bit);
                errors++;
            end
            if (got.device_addr !== want.device_addr) begin
                $error("device_addr: expected %0d, got %0d", want.device_addr, got.device_addr);
                errors++;
            end
            if (got.command_code !== want.command_code) begin
                $error("command_code: expected %0d, got %0d",
                       want.command_code, got.command_code);
                errors++;
            end
        endfunction

        function int pending();
            return frames_due.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [TIME_W-1:0]      cfg_data;

    rc5_frame_board frame_board;
    int             cur_t;
    logic [ADDR_W-1:0] cur_own;
    bit             calm;
    int             edges_sent;
    int             cycle_count = 0;

    rc5_edge_timing_decoder_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && frame_board != null && m_tvalid === 1'b1 && m_tready === 1'b1)
            frame_board.check_frame(m_tdata);
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_idle();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // accumulated times that take a bit
    function automatic int window_lo();
        return (4 * cur_t) / 5 + 1;
    endfunction

    function automatic int window_hi();
        return (6 * cur_t - 1) / 5;
    endfunction

    function automatic int restart_lo();
        return (3 * cur_t) / 2 + 1;
    endfunction

    function automatic int pick_restart();
        case ($urandom_range(0, 3))
            0:       return restart_lo();
            1:       return 65535;
            default: return $urandom_range(restart_lo(), 65535);
        endcase
    endfunction

    function automatic int pick_total();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return window_lo();
        else if (r < 30)
            return window_hi();
        else
            return $urandom_range(window_lo(), window_hi());
    endfunction

    initial begin
        int stall;
        int run;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = pick_idle();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            run = $urandom_range(1, 8);
            repeat (run) @(posedge clk);
        end
    end

    task automatic send_edge(input logic [GAP_W-1:0] gap, input logic low);
        int idle;
        idle = pick_idle();
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - GAP_W - 1){1'b0}}, low, gap};
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        frame_board.note_edge(gap, low);
        edges_sent++;
    endtask

    // one bit, either as one full-period gap or as two gaps that add up
    task automatic send_bit(input logic low, input int total, input bit split);
        int part;
        if (split && window_lo() >= 2) begin
            part = $urandom_range(1, window_lo() - 1);
            send_edge(GAP_W'(part), 1'($urandom_range(0, 1)));
            send_edge(GAP_W'(total - part), low);
        end
        else begin
            send_edge(GAP_W'(total), low);
        end
    endtask

    task automatic send_frame(input int nbits, input logic [12:0] payload);
        int  i;
        logic low;
        send_edge(GAP_W'(pick_restart()), 1'($urandom_range(0, 1)));
        for (i = 0; i < nbits; i++) begin
            low = (i < 13) ? payload[12 - i] : 1'($urandom_range(0, 1));
            send_bit(low, pick_total(), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic send_noise(input int n);
        int i;
        int g;
        int span;
        for (i = 0; i < n; i++) begin
            span = (2 * cur_t + 1 > 65535) ? 65535 : 2 * cur_t + 1;
            case ($urandom_range(0, 3))
                0:       g = 0;
                1:       g = $urandom_range(0, 65535);
                2:       g = $urandom_range(0, span);
                default: g = (3 * cur_t) / 2 + $urandom_range(0, 1);
            endcase
            send_edge(GAP_W'(g), 1'($urandom_range(0, 1)));
        end
    endtask

    // frame cut short by a gap that overshoots the bit window
    task automatic send_broken();
        int i;
        int k;
        send_edge(GAP_W'(pick_restart()), 1'($urandom_range(0, 1)));
        k = $urandom_range(0, 12);
        for (i = 0; i < k; i++)
            send_bit(1'($urandom_range(0, 1)), pick_total(), 1'($urandom_range(0, 1)));
        if (window_hi() + 1 <= (3 * cur_t) / 2)
            send_edge(GAP_W'($urandom_range(window_hi() + 1, (3 * cur_t) / 2)),
                      1'($urandom_range(0, 1)));
        send_noise($urandom_range(1, 4));
    endtask

    // longest gaps that do not restart, until the accumulator pins
    task automatic send_saturation();
        int i;
        int g;
        int n;
        g = (3 * cur_t) / 2;
        n = ACC_MAX / g + 4;
        for (i = 0; i < n; i++)
            send_edge(GAP_W'(g), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_random(input int budget);
        int          stop_at;
        int          pick;
        logic [12:0] payload;
        stop_at = edges_sent + budget;
        while (edges_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (cur_t == 0) begin
                send_noise($urandom_range(1, 8));
            end
            else if (pick < 70) begin
                payload = 13'($urandom_range(0, 8191));
                if ($urandom_range(0, 1))
                    payload[10:6] = cur_own;
                send_frame(($urandom_range(0, 4) == 0) ? $urandom_range(14, 20) : 13, payload);
            end
            else if (pick < 80) begin
                send_broken();
            end
            else if (pick < 95 || cur_t < 8192) begin
                send_noise($urandom_range(1, 10));
            end
            else begin
                send_saturation();
            end
        end
    endtask

    task automatic run_directed();
        int i;
        send_edge(16'hFFFF, 1'b0);
        // exactly 1.5 bit times does not restart
        send_edge(GAP_W'(restart_lo() - 1), 1'b1);
        send_edge(GAP_W'(restart_lo()), 1'b0);
        // just under the window, a zero gap, then one more microsecond takes a bit
        send_edge(GAP_W'(window_lo() - 1), 1'b1);
        send_edge(16'd0, 1'b0);
        send_edge(16'd1, 1'b1);
        // all-ones frame on the window edges, then one bit past the frame
        send_edge(16'hFFFF, 1'b0);
        for (i = 0; i < 13; i++)
            send_bit(1'b1, (i % 2) ? window_hi() : window_lo(), (i % 3) == 0);
        send_bit(1'b0, window_hi(), 1'b0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TIME_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        frame_board.write_reg(idx, value);
    endtask

    task automatic configure(input logic [TIME_W-1:0] t, input logic [ADDR_W-1:0] own,
                             input logic any_addr);
        write_reg(CFG_BIT_TIME, t);
        write_reg(CFG_OWN_ADDRESS, TIME_W'(own));
        write_reg(CFG_ACCEPT_ALL, TIME_W'(any_addr));
        cfg_we  <= 1'b0;
        cur_t   = int'(t);
        cur_own = own;
        calm    = ($urandom_range(0, 3) == 0);
    endtask

    // no frame may still be in flight when the registers change
    task automatic drain();
        s_tvalid <= 1'b0;
        while (frame_board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        edges_sent  = 0;
        calm        = 1'b0;
        cur_t       = int'(BIT_TIME_RST);
        cur_own     = OWN_ADDRESS_RST;
        frame_board = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(BIT_TIME_RST, OWN_ADDRESS_RST, ACCEPT_ALL_RST);
        run_directed();
        run_random(230);
        drain();

        configure(14'd1, 5'd31, 1'b0);
        run_random(200);
        drain();

        configure(14'd16383, 5'd21, 1'b0);
        run_random(250);
        drain();

        // zero bit time: nonzero gaps restart, nothing is ever sampled
        configure(14'd0, 5'd5, 1'b1);
        run_random(40);
        drain();

        configure(14'd889, 5'd10, 1'b1);
        run_random(220);
        drain();

        configure(TIME_W'($urandom_range(2, 16383)), ADDR_W'($urandom_range(0, 31)), 1'b0);
        run_random(220);
        drain();

        configure(TIME_W'($urandom_range(8, 3000)), ADDR_W'($urandom_range(0, 31)),
                  1'($urandom_range(0, 1)));
        run_random(220);
        drain();

        configure(14'd16383, 5'd0, 1'b1);
        run_random(200);
        drain();

        configure(TIME_W'($urandom_range(1, 400)), 5'd31, 1'b0);
        run_random(220);
        drain();

        if (frame_board.errors == 0 && frame_board.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== rc5_edge_timing_decoder_top.f =====
src/rc5_pkg.sv
src/rc5_edge_timing_decoder_top.sv
dv/tb.sv
